@@ rtl/ppc_pkg.sv @@
// Shared constants and types for the polygon point containment block.
package ppc_pkg;

   localparam int PT_BITS   = 16;
   localparam int AREA_BITS = 44;
   localparam int STAT_BITS = 2;

   localparam logic [AREA_BITS-1:0] AREA_MAX = '1;

   localparam logic MODE_ADD   = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef logic [STAT_BITS-1:0] status_type;

   localparam status_type STAT_ADDED   = 2'd0;
   localparam status_type STAT_FULL    = 2'd1;
   localparam status_type STAT_ANSWER  = 2'd2;

   typedef logic signed [PT_BITS-1:0] point_type;
   typedef logic [AREA_BITS-1:0]      area_type;

endpackage

@@ rtl/ppc_if.sv @@
// Request and response channel interfaces for the polygon point containment block.
interface ppc_req_if import ppc_pkg::*; ();
   logic      valid;
   logic      ready;
   logic      mode;
   point_type point_x;
   point_type point_y;

   modport source (output valid, output mode, output point_x, output point_y, input ready);
   modport sink   (input valid, input mode, input point_x, input point_y, output ready);
endinterface

interface ppc_rsp_if import ppc_pkg::*; ();
   logic       valid;
   logic       ready;
   status_type status;
   logic       inside_res;
   area_type   polygon_area_x2;

   modport source (output valid, output status, output inside_res, output polygon_area_x2,
                   input ready);
   modport sink   (input valid, input status, input inside_res, input polygon_area_x2,
                   output ready);
endinterface

@@ rtl/polygon_point_containment.sv @@
// Polygon point containment: vertex store and point-in-polygon area test.
// An append beat (mode 0) stores a vertex, or reports the store full.
// A query beat (mode 1) walks the stored polygon once with a single shared
// multiplier, two products per vertex (trapezoid term of the edge and of the query
// point), and compares the summed triangle areas with the polygon area, all as exact
// doubled integers. A query over stored vertices holds the request side until its
// answer is loaded; an empty store answers at once. The request side
// also waits while a result sits unclaimed in the output register.
module polygon_point_containment import ppc_pkg::*; #(
   parameter int MAX_VERTICES = 64,
   parameter int COORD_BITS   = 16
) (
   input  logic     clock,
   input  logic     reset,
   ppc_req_if.sink   req_ch,
   ppc_rsp_if.source rsp_ch
);

   localparam int CW = COORD_BITS;
   localparam int RW = (CW > PT_BITS) ? CW : PT_BITS;
   localparam int OW = CW + 1;
   localparam int PW = 2 * OW;
   localparam int SW = PW + 2;
   localparam int IW = $clog2(MAX_VERTICES + 1);
   localparam int AD = $clog2(MAX_VERTICES);
   localparam int AW = SW + IW;
   localparam int EW = (AW > AREA_BITS) ? AW : AREA_BITS;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_U    = 3'd1;
   localparam logic [2:0] ST_T    = 3'd2;
   localparam logic [2:0] ST_FIN1 = 3'd3;
   localparam logic [2:0] ST_FIN2 = 3'd4;
   localparam logic [2:0] ST_CMP  = 3'd5;

   // vertex store, {y, x}
   logic [2*CW-1:0] vertex_mem_ff [MAX_VERTICES];
   logic [2*CW-1:0] rd_data_ff;
   logic [AD-1:0]   rd_addr;
   logic            wr_en;

   logic [2:0]      state_ff, state_in;
   logic [IW-1:0]   count_ff, count_in;
   logic [IW-1:0]   idx_ff, idx_in;
   logic [IW-1:0]   idx_nxt;

   logic signed [CW-1:0] qx_ff, qy_ff, in_x, in_y;
   logic signed [CW-1:0] cur_x_ff, cur_y_ff, prev_x_ff, prev_y_ff;
   logic signed [CW-1:0] rd_x, rd_y;
   logic [RW-1:0]        raw_x, raw_y;

   logic signed [OW-1:0] op_a, op_b;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic signed [PW-1:0] u_new_ff, u_old_ff;
   logic                 edge_ff, edge_in;
   logic                 s_vld_ff;
   logic signed [SW-1:0] s_ff;
   logic [SW-1:0]        s_abs;
   logic signed [AW-1:0] poly_ff;
   logic [AW-1:0]        tri_ff;
   logic [AW-1:0]        poly_abs;
   logic [EW-1:0]        poly_ext;

   logic                 acc_clr;
   logic                 out_free, out_load;
   status_type           status_ff, status_in;
   logic                 inside_ff, inside_in;
   area_type             area_ff, area_in;
   logic                 rsp_vld_ff;
   logic                 accept;

   assign raw_x = RW'($unsigned(req_ch.point_x));
   assign raw_y = RW'($unsigned(req_ch.point_y));
   assign in_x  = signed'(raw_x[CW-1:0]);
   assign in_y  = signed'(raw_y[CW-1:0]);

   assign rd_x = signed'(rd_data_ff[CW-1:0]);
   assign rd_y = signed'(rd_data_ff[2*CW-1:CW]);

   assign out_free      = !rsp_vld_ff || rsp_ch.ready;
   assign req_ch.ready  = (state_ff == ST_IDLE) && out_free;
   assign accept        = req_ch.valid && req_ch.ready;
   assign wr_en         = accept && (req_ch.mode == MODE_ADD) &&
                          (count_ff < IW'(MAX_VERTICES));

   assign idx_nxt = idx_ff + IW'(1);

   // read address: vertex 0 at query start, then next vertex around the ring
   always_comb begin
      rd_addr = '0;
      if (state_ff == ST_T && idx_nxt != count_ff) begin
         rd_addr = idx_nxt[AD-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         vertex_mem_ff[count_ff[AD-1:0]] <= {in_y, in_x};
      end
      rd_data_ff <= vertex_mem_ff[rd_addr];
   end

   // shared multiplier operand select
   always_comb begin
      if (state_ff == ST_U) begin
         op_a = OW'(rd_y) + OW'(qy_ff);
         op_b = OW'(rd_x) - OW'(qx_ff);
      end else begin
         op_a = OW'(cur_y_ff) + OW'(prev_y_ff);
         op_b = OW'(cur_x_ff) - OW'(prev_x_ff);
      end
      prod_in = PW'(op_a) * PW'(op_b);
   end

   assign s_abs    = s_ff[SW-1] ? SW'(-s_ff) : SW'(s_ff);
   assign poly_abs = poly_ff[AW-1] ? AW'(-poly_ff) : AW'(poly_ff);
   assign poly_ext = EW'(poly_abs);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      edge_in   = 1'b0;
      acc_clr   = 1'b0;
      out_load  = 1'b0;
      status_in = status_ff;
      inside_in = inside_ff;
      area_in   = area_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_ch.mode == MODE_ADD) begin
                  out_load  = 1'b1;
                  inside_in = 1'b0;
                  area_in   = '0;
                  if (wr_en) begin
                     count_in  = count_ff + IW'(1);
                     status_in = STAT_ADDED;
                  end else begin
                     status_in = STAT_FULL;
                  end
               end else if (count_ff == '0) begin
                  out_load  = 1'b1;
                  status_in = STAT_ANSWER;
                  inside_in = 1'b1;
                  area_in   = '0;
               end else begin
                  acc_clr  = 1'b1;
                  idx_in   = '0;
                  state_in = ST_U;
               end
            end
         end
         ST_U: begin
            state_in = ST_T;
         end
         ST_T: begin
            edge_in = (idx_ff != '0);
            idx_in  = idx_nxt;
            state_in = (idx_ff == count_ff) ? ST_FIN1 : ST_U;
         end
         ST_FIN1: begin
            state_in = ST_FIN2;
         end
         ST_FIN2: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (out_free) begin
               out_load  = 1'b1;
               status_in = STAT_ANSWER;
               inside_in = (tri_ff == poly_abs);
               area_in   = (poly_ext > EW'(AREA_MAX)) ? AREA_MAX : poly_ext[AREA_BITS-1:0];
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         idx_ff     <= '0;
         edge_ff    <= 1'b0;
         s_vld_ff   <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
         edge_ff  <= edge_in;
         s_vld_ff <= edge_ff;
         if (out_load) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   // datapath: operands, products, two-stage accumulation
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      inside_ff <= inside_in;
      area_ff   <= area_in;
      if (accept) begin
         qx_ff <= in_x;
         qy_ff <= in_y;
      end
      if (state_ff == ST_U) begin
         cur_x_ff  <= rd_x;
         cur_y_ff  <= rd_y;
         prev_x_ff <= cur_x_ff;
         prev_y_ff <= cur_y_ff;
      end
      if (state_ff == ST_T) begin
         u_new_ff <= prod_ff;
         u_old_ff <= u_new_ff;
      end
      prod_ff <= prod_in;
      if (edge_ff) begin
         s_ff <= SW'(prod_ff) + SW'(u_old_ff) - SW'(u_new_ff);
      end
      if (acc_clr) begin
         poly_ff <= '0;
         tri_ff  <= '0;
      end else begin
         if (edge_ff) begin
            poly_ff <= poly_ff + AW'(prod_ff);
         end
         if (s_vld_ff) begin
            tri_ff <= tri_ff + AW'(s_abs);
         end
      end
   end

   assign rsp_ch.valid           = rsp_vld_ff;
   assign rsp_ch.status          = status_ff;
   assign rsp_ch.inside_res      = inside_ff;
   assign rsp_ch.polygon_area_x2 = area_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= IW'(MAX_VERTICES))
      else $error("vertex count above store depth");

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ch.ready)
      else $error("request ready during query walk");

   a_edge_state: assert property (@(posedge clock) disable iff (reset)
      edge_ff |-> (state_ff == ST_U || state_ff == ST_FIN1))
      else $error("edge term outside accumulate slot");

   a_add_answers: assert property (@(posedge clock) disable iff (reset)
      (accept && req_ch.mode == MODE_ADD) |=> (rsp_vld_ff && status_ff != STAT_ANSWER))
      else $error("append beat without append response");

endmodule

@@ test/containment_monitor.sv @@
// Watches both channels, predicts each answer of the polygon store and compares it.
module containment_monitor import ppc_pkg::*; #(
   parameter int MAX_VERTICES = 64,
   parameter int COORD_BITS   = 16
) (
   input  logic clock,
   input  logic reset,
   ppc_req_if   req_mon,
   ppc_rsp_if   rsp_mon,
   output int   fail_count,
   output int   results_seen,
   output int   outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      status_type status;
      logic       in_poly;
      area_type   area;
   } answer_type;

   longint      vert_x [MAX_VERTICES];
   longint      vert_y [MAX_VERTICES];
   int unsigned stored;
   answer_type  pending_answers [$];

   function automatic longint coord_value(point_type raw);
      longint v;
      v = longint'($unsigned(raw));
      v = (v <<< (64 - COORD_BITS)) >>> (64 - COORD_BITS);
      return v;
   endfunction

   // doubled signed area under the edge a -> b
   function automatic longint trapezoid2(longint ax, longint ay, longint bx, longint by);
      return (by + ay) * (bx - ax);
   endfunction

   function automatic answer_type answer_beat(logic mode, point_type raw_x, point_type raw_y);
      answer_type         a;
      longint             px, py, poly, wedge;
      longint unsigned    poly_abs, wedge_total;
      int unsigned        nxt;
      px = coord_value(raw_x);
      py = coord_value(raw_y);
      a.status  = STAT_ADDED;
      a.in_poly = 1'b0;
      a.area    = '0;
      if (mode == MODE_ADD) begin
         if (stored >= MAX_VERTICES) begin
            a.status = STAT_FULL;
         end else begin
            vert_x[stored] = px;
            vert_y[stored] = py;
            stored++;
         end
         return a;
      end
      poly        = 0;
      wedge_total = 0;
      for (int unsigned i = 0; i < stored; i++) begin
         nxt = (i + 1 == stored) ? 0 : i + 1;
         poly += trapezoid2(vert_x[i], vert_y[i], vert_x[nxt], vert_y[nxt]);
         wedge = trapezoid2(px, py, vert_x[i], vert_y[i]) +
                 trapezoid2(vert_x[i], vert_y[i], vert_x[nxt], vert_y[nxt]) +
                 trapezoid2(vert_x[nxt], vert_y[nxt], px, py);
         wedge_total += (wedge < 0) ? -wedge : wedge;
      end
      poly_abs = (poly < 0) ? -poly : poly;
      a.status  = STAT_ANSWER;
      a.in_poly = (wedge_total == poly_abs);
      a.area    = (poly_abs > AREA_MAX) ? AREA_MAX : poly_abs[AREA_BITS-1:0];
      return a;
   endfunction

   always @(posedge clock) begin : watch
      answer_type got, want;
      int         errs;
      if (reset) begin
         stored = 0;
         pending_answers.delete();
         fail_count   <= 0;
         results_seen <= 0;
         outstanding  <= 0;
      end else begin
         errs = 0;
         if (req_mon.valid && req_mon.ready)
            pending_answers.insert(pending_answers.size(),
                                   answer_beat(req_mon.mode, req_mon.point_x,
                                               req_mon.point_y));
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.status  = rsp_mon.status;
            got.in_poly = rsp_mon.inside_res;
            got.area    = rsp_mon.polygon_area_x2;
            if (pending_answers.size() == 0) begin
               $display("%t: beat with nothing expected: status %0d inside %0d area %0d",
                        $time, got.status, got.in_poly, got.area);
               errs++;
            end else begin
               want = pending_answers.pop_front();
               if (got.status !== want.status) begin
                  $display("%t: status expected %0d, got %0d", $time, want.status, got.status);
                  errs++;
               end
               if (got.in_poly !== want.in_poly) begin
                  $display("%t: inside_res expected %0d, got %0d", $time, want.in_poly,
                           got.in_poly);
                  errs++;
               end
               if (got.area !== want.area) begin
                  $display("%t: polygon_area_x2 expected %0d, got %0d", $time, want.area,
                           got.area);
                  errs++;
               end
            end
            results_seen <= results_seen + 1;
         end
         fail_count  <= fail_count + errs;
         outstanding <= pending_answers.size();
      end
   end

endmodule

@@ test/testbench.sv @@
// Stimulus and verdict for the polygon point containment block.
module testbench import ppc_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_VERTICES = 64;
   localparam int COORD_BITS   = 16;
   localparam int ITEMS        = 1200;
   localparam int DRAIN_CYCLES = 2 * MAX_VERTICES + 40;
   localparam int RUN_LIMIT    = 1000000;
   localparam int HOLDOFF      = 1500;

   logic clock;
   logic reset;
   int   items_sent;
   int   burst_left;
   int   run_cycles;
   int   fail_count, results_seen, outstanding;

   // diamond rim, counterclockwise from the left corner; all edges at slope +-1
   int corner_x [4] = '{-32767, 0, 32767, 0};
   int corner_y [4] = '{0, -32767, 0, 32767};
   int step_x   [4] = '{1, 1, -1, -1};
   int step_y   [4] = '{-1, 1, 1, -1};
   int rim_x [MAX_VERTICES];
   int rim_y [MAX_VERTICES];

   ppc_req_if req_bus ();
   ppc_rsp_if rsp_bus ();

   polygon_point_containment #(
      .MAX_VERTICES(MAX_VERTICES),
      .COORD_BITS  (COORD_BITS)
   ) uut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_bus),
      .rsp_ch(rsp_bus)
   );

   containment_monitor #(
      .MAX_VERTICES(MAX_VERTICES),
      .COORD_BITS  (COORD_BITS)
   ) monitor (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .fail_count  (fail_count),
      .results_seen(results_seen),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      run_cycles <= run_cycles + 1;
      if (run_cycles >= RUN_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   task automatic offer(logic mode, point_type x, point_type y);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_bus.valid   <= 1'b1;
      req_bus.mode    <= mode;
      req_bus.point_x <= x;
      req_bus.point_y <= y;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      items_sent++;
   endtask

   // result side: stall segments of random kind, plus one long hold-off
   initial begin : receiver
      int  seg, len, rx_cycles;
      bit  held;
      rx_cycles = 0;
      held      = 1'b0;
      forever begin
         if (!held && rx_cycles >= 3000) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLDOFF) @(posedge clock);
            rx_cycles += HOLDOFF;
            held = 1'b1;
         end else begin
            seg = $urandom_range(0, 3);
            len = (seg == 3) ? $urandom_range(1, 40) : $urandom_range(10, 150);
            repeat (len) begin
               case (seg)
                  0: rsp_bus.ready <= 1'b1;
                  1: rsp_bus.ready <= 1'($urandom_range(0, 1));
                  2: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
                  default: rsp_bus.ready <= 1'b0;
               endcase
               @(posedge clock);
               rx_cycles++;
            end
         end
      end
   end

   initial begin : stimulus
      int t, half, appended, kind, idx, lim, qx, qy, e;
      run_cycles      = 0;
      items_sent      = 0;
      burst_left      = 0;
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.mode    <= MODE_ADD;
      req_bus.point_x <= '0;
      req_bus.point_y <= '0;
      for (int s = 0; s < 4; s++) begin
         for (int k = 0; k < 16; k++) begin
            t = (k == 0) ? 0 : k * 2048 + int'($urandom_range(0, 1023)) - 512;
            rim_x[s*16 + k] = corner_x[s] + step_x[s] * t;
            rim_y[s*16 + k] = corner_y[s] + step_y[s] * t;
         end
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: empty store, one and two collinear vertices, three and four vertices, field extremes
      half = (rim_x[1] - rim_x[0]) / 2;
      offer(MODE_QUERY, point_type'(0), point_type'(0));
      offer(MODE_QUERY, point_type'(-32768), point_type'(-32768));
      offer(MODE_ADD, point_type'(rim_x[0]), point_type'(rim_y[0]));
      offer(MODE_QUERY, point_type'(rim_x[0]), point_type'(rim_y[0]));
      offer(MODE_QUERY, point_type'(32767), point_type'(32767));
      offer(MODE_ADD, point_type'(rim_x[1]), point_type'(rim_y[1]));
      offer(MODE_QUERY, point_type'(rim_x[0] + half), point_type'(rim_y[0] - half));
      offer(MODE_QUERY, point_type'(0), point_type'(0));
      offer(MODE_ADD, point_type'(rim_x[2]), point_type'(rim_y[2]));
      offer(MODE_QUERY, point_type'(-32768), point_type'(32767));
      offer(MODE_ADD, point_type'(rim_x[3]), point_type'(rim_y[3]));
      offer(MODE_QUERY, point_type'(rim_x[2]), point_type'(rim_y[2]));
      offer(MODE_QUERY, point_type'(32767), point_type'(-32768));
      offer(MODE_QUERY, point_type'(-1), point_type'(0));
      appended = 4;

      // random: finish the rim amid queries, then queries with some dropped appends mixed in
      for (int n = 0; n < ITEMS; n++) begin
         if (appended < MAX_VERTICES && $urandom_range(0, 1) == 0) begin
            offer(MODE_ADD, point_type'(rim_x[appended]), point_type'(rim_y[appended]));
            appended++;
         end else if (appended == MAX_VERTICES && $urandom_range(0, 9) == 0) begin
            offer(MODE_ADD, point_type'($urandom_range(0, 65535)),
                  point_type'($urandom_range(0, 65535)));
         end else begin
            kind = $urandom_range(0, 4);
            case (kind)
               0: begin
                  qx = int'(point_type'($urandom_range(0, 65535)));
                  qy = int'(point_type'($urandom_range(0, 65535)));
               end
               1: begin
                  qx  = int'($urandom_range(0, 65534)) - 32767;
                  lim = 32767 - ((qx < 0) ? -qx : qx);
                  qy  = int'($urandom_range(0, 2 * lim)) - lim;
               end
               2: begin
                  idx = $urandom_range(0, appended - 1);
                  qx  = rim_x[idx];
                  qy  = rim_y[idx];
               end
               3: begin
                  e  = $urandom_range(0, 3);
                  t  = $urandom_range(0, 32767);
                  qx = corner_x[e] + step_x[e] * t + int'($urandom_range(0, 2)) - 1;
                  qy = corner_y[e] + step_y[e] * t + int'($urandom_range(0, 2)) - 1;
               end
               default: begin
                  qx = $urandom_range(0, 1) ? 32767 : -32768;
                  qy = int'(point_type'($urandom_range(0, 65535)));
                  if ($urandom_range(0, 1)) begin
                     t  = qx;
                     qx = qy;
                     qy = t;
                  end
               end
            endcase
            offer(MODE_QUERY, point_type'(qx), point_type'(qy));
         end
      end
      req_bus.valid <= 1'b0;

      while (results_seen < items_sent) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/ppc_pkg.sv
rtl/ppc_if.sv
rtl/polygon_point_containment.sv
test/containment_monitor.sv
test/testbench.sv
